>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the state-feedback controller RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define HSFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define HSFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared field widths, request codes, register indexes and section codes of
// the history state-feedback controller.
// ----------------------------------------------------------------------------
package hsfc_pkg;

    localparam int VAL_W       = 16;
    localparam int ACTION_W    = 2;
    localparam int ELEM_W      = 4;
    localparam int COL_FIELD_W = 7;
    localparam int MODE_OUT_W  = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FRAC_SHIFT  = 14;

    typedef logic [ACTION_W-1:0] action_t;
    localparam action_t ACT_LOAD_COEF = 2'd0;
    localparam action_t ACT_ACCEL     = 2'd1;
    localparam action_t ACT_MEAS      = 2'd2;
    localparam action_t ACT_CLEAR     = 2'd3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ACTIVE_MODES    = 3'd0;
    localparam cfg_idx_t CFG_HISTORY_STEPS   = 3'd1;
    localparam cfg_idx_t CFG_ACCEL_CHANNELS  = 3'd2;
    localparam cfg_idx_t CFG_ACCEL_STEPS     = 3'd3;
    localparam cfg_idx_t CFG_INTEGRATOR_GAIN = 3'd4;

    // Part of the state vector a term comes from
    typedef logic [1:0] section_t;
    localparam section_t SEC_CMD  = 2'd0;
    localparam section_t SEC_ACC  = 2'd1;
    localparam section_t SEC_MEAS = 2'd2;
    localparam section_t SEC_GAIN = 2'd3;

    // Tag that travels with one multiply-accumulate term
    typedef struct packed {
        logic     vld;
        section_t sec;
        logic     first;
        logic     last;
    } term_tag_t;

endpackage

>>> rtl/hsfc_if.sv
// ----------------------------------------------------------------------------
// hsfc_if
// Valid/ready channels of the controller: input requests and command results.
// ----------------------------------------------------------------------------
interface hsfc_item_if import hsfc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACTION_W-1:0]     action;
    logic [ELEM_W-1:0]       element;
    logic [COL_FIELD_W-1:0]  column;
    logic signed [VAL_W-1:0] sample_value;
    logic signed [VAL_W-1:0] noise;

    modport source (output valid, action, element, column, sample_value, noise,
                    input ready);
    modport sink   (input valid, action, element, column, sample_value, noise,
                    output ready);
endinterface

interface hsfc_result_if import hsfc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] command;
    logic [MODE_OUT_W-1:0]   mode;
    logic                    last;
    logic                    saturated;

    modport source (output valid, command, mode, last, saturated, input ready);
    modport sink   (input valid, command, mode, last, saturated, output ready);
endinterface

>>> rtl/hsfc_ram.sv
// ----------------------------------------------------------------------------
// hsfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hsfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/history_state_feedback_controller.sv
// ----------------------------------------------------------------------------
// history_state_feedback_controller
// Gain-matrix state feedback over ring histories of measurements, commands
// and accelerometer samples, one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// After reset the block sweeps the coefficient RAM and the three ring RAMs to
// zero, one entry a cycle (the largest RAM depth, 2048 entries by default), and
// holds item_in.ready low meanwhile; configuration writes are taken at any
// time. Coefficient loads, accelerometer samples and non-final measurements
// leave the block idle. A history clear zeroes the pointers and then sweeps
// the ring RAMs, holding ready low over the larger ring depth (128 entries by
// default). The measurement of the last active mode starts the command pass
// after its accept cycle: one 16x16 multiplier and one accumulator walk the
// state vector, one term a cycle. Each mode passes through a start state, n
// feature terms plus the integrator term, the RAM read and multiply registers
// and the output load, with n = 112 under all defaults (16 modes, 4 history
// steps). A command waits in the output register while the sink stalls,
// holding the pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module history_state_feedback_controller import hsfc_pkg::*; #(
    parameter int MAX_MODES          = 16,
    parameter int MAX_HISTORY        = 4,
    parameter int MAX_ACCEL_CHANNELS = 4,
    parameter int MAX_ACCEL_STEPS    = 4,
    parameter int RING_DEPTH         = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hsfc_item_if.sink             item_in,
    hsfc_result_if.source         result_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int COEF_COLS = (2 * MAX_HISTORY - 1) * MAX_MODES
                               + MAX_ACCEL_CHANNELS * MAX_ACCEL_STEPS;
    localparam int MODE_W    = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int MCNT_W    = $clog2(MAX_MODES + 1);
    localparam int HCNT_W    = $clog2(MAX_HISTORY + 1);
    localparam int ACH_N     = (MAX_ACCEL_CHANNELS > 0) ? MAX_ACCEL_CHANNELS : 1;
    localparam int ACH_W     = (ACH_N > 1) ? $clog2(ACH_N) : 1;
    localparam int ACNT_W    = $clog2(ACH_N + 1);
    localparam int AST_N     = (MAX_ACCEL_STEPS > 0) ? MAX_ACCEL_STEPS : 1;
    localparam int ASCNT_W   = $clog2(AST_N + 1);
    localparam int STEP_MAX  = (MAX_HISTORY > AST_N) ? MAX_HISTORY : AST_N;
    localparam int SCNT_W    = $clog2(STEP_MAX + 1);
    localparam int ELEM_N    = (MAX_MODES > ACH_N) ? MAX_MODES : ACH_N;
    localparam int EIDX_W    = (ELEM_N > 1) ? $clog2(ELEM_N) : 1;
    localparam int SLOT_W    = $clog2(RING_DEPTH);
    localparam int COL_W     = (COEF_COLS > 1) ? $clog2(COEF_COLS) : 1;
    localparam int COEF_AW   = MODE_W + COL_W;
    localparam int COEF_DEPTH = 1 << COEF_AW;
    localparam int MRING_AW  = SLOT_W + MODE_W;
    localparam int MRING_DEPTH = 1 << MRING_AW;
    localparam int ARING_AW  = SLOT_W + ACH_W;
    localparam int ARING_DEPTH = 1 << ARING_AW;
    localparam int RCLR_DEPTH  = (MRING_DEPTH > ARING_DEPTH) ? MRING_DEPTH : ARING_DEPTH;
    localparam int SWEEP_DEPTH = (COEF_DEPTH > RCLR_DEPTH) ? COEF_DEPTH : RCLR_DEPTH;
    localparam int SWEEP_AW    = $clog2(SWEEP_DEPTH);
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ACC_W     = PROD_W + $clog2(COEF_COLS + 2) + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_ISSUE = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_RCLR  = 3'd5;

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == '0)
            r = SLOT_W'(RING_DEPTH - 1);
        else
            r = s - SLOT_W'(1);
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(RING_DEPTH - 1))
            r = '0;
        else
            r = s + SLOT_W'(1);
        return r;
    endfunction

    // Configuration registers
    logic [MCNT_W-1:0]       am_reg;
    logic [HCNT_W-1:0]       hs_reg;
    logic [ACNT_W-1:0]       ac_reg;
    logic [ASCNT_W-1:0]      as_reg;
    logic signed [VAL_W-1:0] gain_reg;

    // Sequencer and history state
    logic [2:0]          state_reg;
    logic [SWEEP_AW-1:0] clr_reg;
    logic [SLOT_W-1:0]   mp_reg, cp_reg, ap_reg;
    logic [VAL_W-1:0]    noise_mem [MAX_MODES];
    logic [MODE_W-1:0]   mode_reg;
    logic [COL_W-1:0]    col_reg;
    section_t            sec_reg;
    logic [SCNT_W-1:0]   step_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [EIDX_W-1:0]   elem_reg;
    logic                first_reg;

    // Datapath pipeline
    term_tag_t           p1_tag_reg, p2_tag_reg;
    logic [MODE_W-1:0]   p1_mode_reg, p2_mode_reg;
    logic signed [PROD_W-1:0] p2_prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                fin_reg;

    // Output register
    logic                    out_vld_reg;
    logic signed [VAL_W-1:0] out_cmd_reg;
    logic [MODE_OUT_W-1:0]   out_mode_reg;
    logic                    out_last_reg;
    logic                    out_sat_reg;

    // RAM ports
    logic [VAL_W-1:0]    coef_rd, meas_rd, cmd_rd, accel_rd;
    logic                coef_we, meas_we, cmd_we, accel_we;
    logic [COEF_AW-1:0]  coef_waddr, coef_raddr;
    logic [VAL_W-1:0]    coef_wdata, meas_wdata, cmd_wdata, accel_wdata;
    logic [MRING_AW-1:0] meas_waddr, meas_raddr, cmd_waddr, cmd_raddr;
    logic [ARING_AW-1:0] accel_waddr, accel_raddr;
    logic                ring_clr;

    // Decode of the incoming request
    logic in_acc, meas_ok, meas_final, accel_ok, accel_final, coef_ok;
    logic [MODE_W-1:0] in_mode;
    logic [ACH_W-1:0]  in_ch;

    assign item_in.ready = (state_reg == ST_IDLE);
    assign in_acc  = item_in.valid && item_in.ready;
    assign in_mode = MODE_W'(item_in.element);
    assign in_ch   = ACH_W'(item_in.element);

    assign meas_ok    = (item_in.action == ACT_MEAS)
                        && (int'(item_in.element) < int'(am_reg));
    assign meas_final = meas_ok && (int'(item_in.element) == int'(am_reg) - 1);
    assign accel_ok   = (item_in.action == ACT_ACCEL) && (ac_reg != '0)
                        && (int'(item_in.element) < int'(ac_reg));
    assign accel_final = (int'(item_in.element) == int'(ac_reg) - 1);
    assign coef_ok    = (item_in.action == ACT_LOAD_COEF)
                        && (int'(item_in.element) < MAX_MODES)
                        && (int'(item_in.column) < COEF_COLS);

    // Section walk: where a mode starts and where each section hands over
    logic               acc_used;
    section_t           start_sec, end_sec;
    logic [SLOT_W-1:0]  start_slot, end_slot, newest_meas_slot;
    int                 row_len, step_lim;
    logic               row_end, sec_end;

    assign acc_used         = (ac_reg != '0) && (as_reg != '0);
    assign newest_meas_slot = slot_dec(mp_reg);

    always_comb
    begin
        priority if (int'(hs_reg) > 1)
        begin
            start_sec  = SEC_CMD;
            start_slot = slot_dec(cp_reg);
        end
        else if (acc_used)
        begin
            start_sec  = SEC_ACC;
            start_slot = slot_dec(ap_reg);
        end
        else
        begin
            start_sec  = SEC_MEAS;
            start_slot = newest_meas_slot;
        end
    end

    always_comb
    begin
        end_slot = newest_meas_slot;
        unique case (sec_reg)
            SEC_CMD:
            begin
                if (acc_used)
                begin
                    end_sec  = SEC_ACC;
                    end_slot = slot_dec(ap_reg);
                end
                else
                begin
                    end_sec = SEC_MEAS;
                end
            end
            SEC_ACC:  end_sec = SEC_MEAS;
            SEC_MEAS: end_sec = SEC_GAIN;
            default:  end_sec = SEC_GAIN;
        endcase
    end

    always_comb
    begin
        unique case (sec_reg)
            SEC_CMD:
            begin
                row_len  = int'(am_reg);
                step_lim = int'(hs_reg) - 1;
            end
            SEC_ACC:
            begin
                row_len  = int'(ac_reg);
                step_lim = int'(as_reg);
            end
            default:
            begin
                row_len  = int'(am_reg);
                step_lim = int'(hs_reg);
            end
        endcase
    end

    assign row_end = (int'(elem_reg) == row_len - 1);
    assign sec_end = (int'(step_reg) == step_lim);

    // Rounding and saturation of the finished sum
    logic signed [ACC_W-1:0] round_sum, round_q;
    logic                    q_fits, q_sat;
    logic signed [VAL_W-1:0] q_val;

    assign round_sum = acc_reg + ACC_W'(1 << (FRAC_SHIFT - 1));
    assign round_q   = round_sum >>> FRAC_SHIFT;
    assign q_fits    = (&round_q[ACC_W-1:VAL_W-1]) || (~|round_q[ACC_W-1:VAL_W-1]);
    assign q_sat     = !q_fits;
    assign q_val     = q_fits ? round_q[VAL_W-1:0]
                     : (round_q[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                         : {1'b0, {(VAL_W-1){1'b1}}});

    logic out_free, out_load, last_mode;
    assign out_free  = !out_vld_reg || result_out.ready;
    assign last_mode = (int'(mode_reg) == int'(am_reg) - 1);
    assign out_load  = (state_reg == ST_WAIT) && fin_reg && out_free;

    // RAM port wiring; the rings are swept to zero after reset and on a clear
    assign ring_clr   = (state_reg == ST_CLEAR) || (state_reg == ST_RCLR);

    assign coef_we    = (state_reg == ST_CLEAR) || (in_acc && coef_ok);
    assign coef_waddr = (state_reg == ST_CLEAR) ? clr_reg[COEF_AW-1:0]
                                                : {in_mode, COL_W'(item_in.column)};
    assign coef_wdata = (state_reg == ST_CLEAR) ? '0 : item_in.sample_value;
    assign coef_raddr = {mode_reg, col_reg};

    assign meas_we    = ring_clr || (in_acc && meas_ok);
    assign meas_waddr = ring_clr ? clr_reg[MRING_AW-1:0] : {mp_reg, in_mode};
    assign meas_wdata = ring_clr ? '0 : item_in.sample_value;
    assign meas_raddr = (sec_reg == SEC_GAIN) ? {newest_meas_slot, mode_reg}
                                              : {slot_reg, MODE_W'(elem_reg)};

    assign cmd_we    = ring_clr || out_load;
    assign cmd_waddr = ring_clr ? clr_reg[MRING_AW-1:0] : {cp_reg, mode_reg};
    assign cmd_wdata = ring_clr ? '0 : q_val;
    assign cmd_raddr = {slot_reg, MODE_W'(elem_reg)};

    assign accel_we    = ring_clr || (in_acc && accel_ok);
    assign accel_waddr = ring_clr ? clr_reg[ARING_AW-1:0] : {ap_reg, in_ch};
    assign accel_wdata = ring_clr ? '0 : item_in.sample_value;
    assign accel_raddr = {slot_reg, ACH_W'(elem_reg)};

    hsfc_ram #(.WIDTH(VAL_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
        .raddr(coef_raddr), .rdata(coef_rd)
    );

    hsfc_ram #(.WIDTH(VAL_W), .DEPTH(MRING_DEPTH)) u_meas_ram (
        .clk(clk), .we(meas_we), .waddr(meas_waddr), .wdata(meas_wdata),
        .raddr(meas_raddr), .rdata(meas_rd)
    );

    hsfc_ram #(.WIDTH(VAL_W), .DEPTH(MRING_DEPTH)) u_cmd_ram (
        .clk(clk), .we(cmd_we), .waddr(cmd_waddr), .wdata(cmd_wdata),
        .raddr(cmd_raddr), .rdata(cmd_rd)
    );

    hsfc_ram #(.WIDTH(VAL_W), .DEPTH(ARING_DEPTH)) u_accel_ram (
        .clk(clk), .we(accel_we), .waddr(accel_waddr), .wdata(accel_wdata),
        .raddr(accel_raddr), .rdata(accel_rd)
    );

    // Configuration writes, clamped to the supported ranges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            am_reg   <= MCNT_W'((MAX_MODES < 16) ? MAX_MODES : 16);
            hs_reg   <= HCNT_W'((MAX_HISTORY < 4) ? MAX_HISTORY : 4);
            ac_reg   <= '0;
            as_reg   <= '0;
            gain_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_MODES:
                begin
                    if (cfg_wdata[4:0] == '0)
                        am_reg <= MCNT_W'(1);
                    else if (int'(cfg_wdata[4:0]) > MAX_MODES)
                        am_reg <= MCNT_W'(MAX_MODES);
                    else
                        am_reg <= MCNT_W'(cfg_wdata[4:0]);
                end
                CFG_HISTORY_STEPS:
                begin
                    if (cfg_wdata[2:0] == '0)
                        hs_reg <= HCNT_W'(1);
                    else if (int'(cfg_wdata[2:0]) > MAX_HISTORY)
                        hs_reg <= HCNT_W'(MAX_HISTORY);
                    else
                        hs_reg <= HCNT_W'(cfg_wdata[2:0]);
                end
                CFG_ACCEL_CHANNELS:
                begin
                    if (int'(cfg_wdata[2:0]) > MAX_ACCEL_CHANNELS)
                        ac_reg <= ACNT_W'(MAX_ACCEL_CHANNELS);
                    else
                        ac_reg <= ACNT_W'(cfg_wdata[2:0]);
                end
                CFG_ACCEL_STEPS:
                begin
                    if (int'(cfg_wdata[2:0]) > MAX_ACCEL_STEPS)
                        as_reg <= ASCNT_W'(MAX_ACCEL_STEPS);
                    else
                        as_reg <= ASCNT_W'(cfg_wdata[2:0]);
                end
                CFG_INTEGRATOR_GAIN: gain_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Store the exploration noise of each measured mode
    always_ff @(posedge clk)
    begin
        if (in_acc && meas_ok)
        begin
            noise_mem[in_mode] <= item_in.noise;
        end
    end

    // Sequencer and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            mp_reg    <= '0;
            cp_reg    <= '0;
            ap_reg    <= '0;
            mode_reg  <= '0;
            col_reg   <= '0;
            sec_reg   <= SEC_CMD;
            step_reg  <= '0;
            slot_reg  <= '0;
            elem_reg  <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    // sweep the coefficient and ring RAMs to zero
                    if (clr_reg == SWEEP_AW'(SWEEP_DEPTH - 1))
                    begin
                        clr_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + SWEEP_AW'(1);
                    end
                end
                ST_RCLR:
                begin
                    // sweep the ring RAMs to zero
                    if (clr_reg == SWEEP_AW'(RCLR_DEPTH - 1))
                    begin
                        clr_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + SWEEP_AW'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (item_in.action)
                            ACT_ACCEL:
                            begin
                                if (accel_ok && accel_final)
                                    ap_reg <= slot_inc(ap_reg);
                            end
                            ACT_MEAS:
                            begin
                                if (meas_final)
                                begin
                                    mp_reg    <= slot_inc(mp_reg);
                                    mode_reg  <= '0;
                                    state_reg <= ST_START;
                                end
                            end
                            ACT_CLEAR:
                            begin
                                mp_reg    <= '0;
                                cp_reg    <= '0;
                                ap_reg    <= '0;
                                state_reg <= ST_RCLR;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_START:
                begin
                    // begin the state-vector walk for this mode
                    sec_reg   <= start_sec;
                    slot_reg  <= start_slot;
                    step_reg  <= SCNT_W'(1);
                    elem_reg  <= '0;
                    col_reg   <= '0;
                    first_reg <= 1'b1;
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    // issue one term, then advance the walk
                    first_reg <= 1'b0;
                    col_reg   <= col_reg + COL_W'(1);
                    if (sec_reg == SEC_GAIN)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else if (row_end)
                    begin
                        elem_reg <= '0;
                        if (sec_end)
                        begin
                            sec_reg  <= end_sec;
                            slot_reg <= end_slot;
                            step_reg <= SCNT_W'(1);
                        end
                        else
                        begin
                            step_reg <= step_reg + SCNT_W'(1);
                            slot_reg <= slot_dec(slot_reg);
                        end
                    end
                    else
                    begin
                        elem_reg <= elem_reg + EIDX_W'(1);
                    end
                end
                ST_WAIT:
                begin
                    // hand the command over and store it as newest
                    if (out_load)
                    begin
                        if (last_mode)
                        begin
                            cp_reg    <= slot_inc(cp_reg);
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            mode_reg  <= mode_reg + MODE_W'(1);
                            state_reg <= ST_START;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Term pipeline control: issue, multiply, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_tag_reg <= '0;
            p2_tag_reg <= '0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            p1_tag_reg.vld   <= (state_reg == ST_ISSUE);
            p1_tag_reg.sec   <= sec_reg;
            p1_tag_reg.first <= first_reg;
            p1_tag_reg.last  <= (sec_reg == SEC_GAIN);
            p2_tag_reg       <= p1_tag_reg;
            if (p2_tag_reg.vld && p2_tag_reg.last)
                fin_reg <= 1'b1;
            else if (out_load)
                fin_reg <= 1'b0;
        end
    end

    // Multiply stage
    logic signed [VAL_W-1:0]  x_val, c_val;
    logic signed [PROD_W-1:0] prod_c;

    always_comb
    begin
        unique case (p1_tag_reg.sec)
            SEC_CMD:  x_val = cmd_rd;
            SEC_ACC:  x_val = accel_rd;
            default:  x_val = meas_rd;
        endcase
        c_val = p1_tag_reg.last ? gain_reg : $signed(coef_rd);
    end

    assign prod_c = c_val * x_val;

    // Accumulate stage, seeded with the mode's noise
    logic signed [ACC_W-1:0] acc_base, noise_term;
    logic [VAL_W-1:0]        noise_rd;

    assign noise_rd   = noise_mem[p2_mode_reg];
    assign noise_term = {{(ACC_W-VAL_W-FRAC_SHIFT){noise_rd[VAL_W-1]}}, noise_rd,
                         {FRAC_SHIFT{1'b0}}};
    assign acc_base   = p2_tag_reg.first ? noise_term : acc_reg;

    always_ff @(posedge clk)
    begin
        p1_mode_reg <= mode_reg;
        p2_mode_reg <= p1_mode_reg;
        p2_prod_reg <= prod_c;
        if (p2_tag_reg.vld)
            acc_reg <= acc_base + {{(ACC_W-PROD_W){p2_prod_reg[PROD_W-1]}}, p2_prod_reg};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cmd_reg  <= q_val;
            out_mode_reg <= MODE_OUT_W'(mode_reg);
            out_last_reg <= last_mode;
            out_sat_reg  <= q_sat;
        end
    end

    assign result_out.valid     = out_vld_reg;
    assign result_out.command   = out_cmd_reg;
    assign result_out.mode      = out_mode_reg;
    assign result_out.last      = out_last_reg;
    assign result_out.saturated = out_sat_reg;

    // Checks on the sequencer
    `HSFC_ASSERT_SAME(a_fin_only_waiting, fin_reg, state_reg == ST_WAIT, "sum done outside wait")
    `HSFC_ASSERT_SAME(a_mode_in_range, state_reg == ST_ISSUE, int'(mode_reg) < int'(am_reg), "mode beyond active range")
    `HSFC_ASSERT_SAME(a_col_in_range, state_reg == ST_ISSUE && sec_reg != SEC_GAIN, int'(col_reg) < COEF_COLS, "column beyond matrix")
    `HSFC_ASSERT_NEXT(a_last_ends_pass, out_load && last_mode, state_reg == ST_IDLE, "pass did not end after last mode")

endmodule

>>> bench/hsfc_checker.sv
// ----------------------------------------------------------------------------
// hsfc_checker
// Watches the request, result and register channels of the state-feedback
// controller. It keeps its own copy of the gain matrix and the ring
// histories, predicts the command vector at each closing measurement, and
// compares every result against the oldest predicted command.
// ----------------------------------------------------------------------------
module hsfc_checker import hsfc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    hsfc_item_if                  item_in,
    hsfc_result_if                result_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending,
    output int                    commands_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODES = 16;
    localparam int COLS  = 128;
    localparam int DEPTH = 8;

    typedef struct {
        logic signed [VAL_W-1:0] command;
        logic [MODE_OUT_W-1:0]   mode;
        logic                    last;
        logic                    saturated;
    } command_t;

    command_t pending_commands[$];

    logic signed [VAL_W-1:0] gain_matrix[MODES][COLS];
    logic signed [VAL_W-1:0] meas_hist[DEPTH][MODES];
    logic signed [VAL_W-1:0] cmd_hist[DEPTH][MODES];
    logic signed [VAL_W-1:0] accel_hist[DEPTH][5];
    logic signed [VAL_W-1:0] mode_noise[MODES];
    int                      meas_ptr, cmd_ptr, accel_ptr;
    int                      n_modes, n_hist, n_chan, n_asteps;
    logic signed [VAL_W-1:0] int_gain;

    assign pending = pending_commands.size();

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic int clip(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic clear_history();
        for (int s = 0; s < DEPTH; s++)
        begin
            for (int j = 0; j < MODES; j++)
            begin
                meas_hist[s][j] = '0;
                cmd_hist[s][j] = '0;
            end
            for (int j = 0; j < 5; j++)
                accel_hist[s][j] = '0;
        end
        meas_ptr = 0;
        cmd_ptr = 0;
        accel_ptr = 0;
    endtask

    // Build the state vector and predict one command per active mode
    task automatic predict_commands();
        logic signed [VAL_W-1:0] x[COLS];
        logic signed [VAL_W-1:0] fresh[MODES];
        int                      n, slot;
        longint                  acc, q;
        command_t                c;
        n = 0;
        for (int i = 0; i + 1 < n_hist; i++)
        begin
            slot = (cmd_ptr + DEPTH - (i + 1)) % DEPTH;
            for (int j = 0; j < n_modes; j++)
                x[n++] = cmd_hist[slot][j];
        end
        if (n_chan != 0)
        begin
            for (int i = 0; i < n_asteps; i++)
            begin
                slot = (accel_ptr + DEPTH - (i + 1)) % DEPTH;
                for (int j = 0; j < n_chan; j++)
                    x[n++] = accel_hist[slot][j];
            end
        end
        for (int i = 0; i < n_hist; i++)
        begin
            slot = (meas_ptr + DEPTH - (i + 1)) % DEPTH;
            for (int j = 0; j < n_modes; j++)
                x[n++] = meas_hist[slot][j];
        end
        slot = (meas_ptr + DEPTH - 1) % DEPTH;
        for (int i = 0; i < n_modes; i++)
        begin
            acc = 0;
            for (int j = 0; j < n; j++)
                acc += longint'(gain_matrix[i][j]) * longint'(x[j]);
            acc += longint'(int_gain) * longint'(meas_hist[slot][i]);
            acc += longint'(mode_noise[i]) * 16384;
            q = (acc + 8192) >>> FRAC_SHIFT;
            c.saturated = 1'b0;
            if (q > 32767)
            begin
                q = 32767;
                c.saturated = 1'b1;
            end
            if (q < -32768)
            begin
                q = -32768;
                c.saturated = 1'b1;
            end
            c.command = q[VAL_W-1:0];
            c.mode = i[MODE_OUT_W-1:0];
            c.last = (i == n_modes - 1);
            fresh[i] = c.command;
            pending_commands.push_back(c);
        end
        for (int i = 0; i < n_modes; i++)
            cmd_hist[cmd_ptr][i] = fresh[i];
        cmd_ptr = (cmd_ptr + 1) % DEPTH;
    endtask

    // Apply one accepted request to the predicted state
    task automatic apply_request();
        int e;
        e = int'(item_in.element);
        case (item_in.action)
            ACT_LOAD_COEF:
                gain_matrix[e][item_in.column] = item_in.sample_value;
            ACT_ACCEL:
                if (n_chan != 0 && e < n_chan)
                begin
                    accel_hist[accel_ptr][e] = item_in.sample_value;
                    if (e == n_chan - 1)
                        accel_ptr = (accel_ptr + 1) % DEPTH;
                end
            ACT_CLEAR:
                clear_history();
            default:
                if (e < n_modes)
                begin
                    meas_hist[meas_ptr][e] = item_in.sample_value;
                    mode_noise[e] = item_in.noise;
                    if (e == n_modes - 1)
                    begin
                        meas_ptr = (meas_ptr + 1) % DEPTH;
                        predict_commands();
                    end
                end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MODES; r++)
            begin
                mode_noise[r] = '0;
                for (int c = 0; c < COLS; c++)
                    gain_matrix[r][c] = '0;
            end
            clear_history();
            n_modes = 16;
            n_hist = 4;
            n_chan = 0;
            n_asteps = 0;
            int_gain = '0;
            pending_commands.delete();
            fail_count = 0;
            commands_seen = 0;
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACTIVE_MODES:    n_modes = clip(int'(cfg_wdata[4:0]), 1, 16);
                    CFG_HISTORY_STEPS:   n_hist = clip(int'(cfg_wdata[2:0]), 1, 4);
                    CFG_ACCEL_CHANNELS:  n_chan = clip(int'(cfg_wdata[2:0]), 0, 4);
                    CFG_ACCEL_STEPS:     n_asteps = clip(int'(cfg_wdata[2:0]), 0, 4);
                    CFG_INTEGRATOR_GAIN: int_gain = cfg_wdata;
                    default: ;
                endcase
            end
            // Compare an accepted command with the oldest prediction
            if (result_out.valid && result_out.ready)
            begin
                commands_seen++;
                if (pending_commands.size() == 0)
                    report($sformatf("unexpected command %0d mode %0d",
                                     result_out.command, result_out.mode));
                else
                begin
                    command_t c;
                    c = pending_commands.pop_front();
                    if (result_out.command !== c.command)
                        report($sformatf("mode %0d command %0d, want %0d",
                                         c.mode, result_out.command, c.command));
                    if (result_out.mode !== c.mode)
                        report($sformatf("mode %0d, want %0d", result_out.mode, c.mode));
                    if (result_out.last !== c.last)
                        report($sformatf("mode %0d last %b, want %b",
                                         c.mode, result_out.last, c.last));
                    if (result_out.saturated !== c.saturated)
                        report($sformatf("mode %0d saturated %b, want %b",
                                         c.mode, result_out.saturated, c.saturated));
                end
            end
            if (item_in.valid && item_in.ready)
                apply_request();
        end
    end

endmodule

>>> bench/tb_history_state_feedback_controller.sv
// ----------------------------------------------------------------------------
// tb_history_state_feedback_controller
// Drives requests and register writes into the state-feedback controller
// through several register settings and handshake pressure profiles; the
// checker beside the block predicts and compares every command.
// ----------------------------------------------------------------------------
module tb_history_state_feedback_controller;
    import hsfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count, pending, commands_seen;
    int                    requests_sent;
    int                    idle_pct, stall_pct;

    hsfc_item_if   item_ch();
    hsfc_result_if result_ch();

    history_state_feedback_controller uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    hsfc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_in       (item_ch),
        .result_out    (result_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .commands_seen (commands_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result side at random
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Stop a hung run
    initial
    begin
        #30ms;
        $display("timeout with %0d commands outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_request(input action_t act, input logic [ELEM_W-1:0] elem,
                                input logic [COL_FIELD_W-1:0] col,
                                input logic [VAL_W-1:0] value,
                                input logic [VAL_W-1:0] nval);
        // Sometimes idle the request side before the request
        if ($urandom_range(99) < idle_pct)
        begin
            item_ch.valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.action = act;
        item_ch.element = elem;
        item_ch.column = col;
        item_ch.sample_value = value;
        item_ch.noise = nval;
        do
            @(posedge clk);
        while (!item_ch.ready);
        @(negedge clk);
        item_ch.valid = 1'b0;
        requests_sent++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Wait until every command is back and the block takes requests again
    task automatic drain();
        while (pending != 0 || !item_ch.ready)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        if ($urandom_range(3) == 0)
            return VAL_W'($urandom_range(65535));
        return VAL_W'($urandom_range(8191) - 4096);
    endfunction

    // Write a register setting, then send well-formed rounds mixed with noise
    task automatic run_phase(input int modes, input int hist, input int chans,
                             input int asteps, input logic [VAL_W-1:0] gain,
                             input int idle, input int stall, input int count);
        int m, ch, next_mode, next_chan, pick;
        drain();
        write_reg(CFG_ACTIVE_MODES, CFG_DATA_W'(modes));
        write_reg(CFG_HISTORY_STEPS, CFG_DATA_W'(hist));
        write_reg(CFG_ACCEL_CHANNELS, CFG_DATA_W'(chans));
        write_reg(CFG_ACCEL_STEPS, CFG_DATA_W'(asteps));
        write_reg(CFG_INTEGRATOR_GAIN, gain);
        m = (modes & 31) == 0 ? 1 : ((modes & 31) > 16 ? 16 : (modes & 31));
        ch = (chans & 7) > 4 ? 4 : (chans & 7);
        idle_pct = idle;
        stall_pct = stall;
        next_mode = 0;
        next_chan = 0;
        for (int k = 0; k < count; k++)
        begin
            // Hold off once until every command of this phase has come back
            if (k == count / 2)
                while (pending != 0)
                    @(negedge clk);
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // Advance the round, sometimes skipping a non-final mode
                if (next_mode < m - 1 && $urandom_range(9) == 0)
                    next_mode++;
                send_request(ACT_MEAS, ELEM_W'(next_mode),
                             COL_FIELD_W'($urandom_range(127)), rand_value(),
                             rand_value());
                next_mode = (next_mode + 1) % m;
            end
            else if (pick < 70)
                send_request(ACT_LOAD_COEF, ELEM_W'($urandom_range(15)),
                             COL_FIELD_W'($urandom_range(127)), rand_value(),
                             VAL_W'($urandom_range(65535)));
            else if (pick < 85)
            begin
                if (ch != 0 && $urandom_range(4) != 0)
                begin
                    send_request(ACT_ACCEL, ELEM_W'(next_chan),
                                 COL_FIELD_W'($urandom_range(127)), rand_value(),
                                 VAL_W'($urandom_range(65535)));
                    next_chan = (next_chan + 1) % ch;
                end
                else
                    send_request(ACT_ACCEL, ELEM_W'($urandom_range(15)),
                                 COL_FIELD_W'($urandom_range(127)), rand_value(),
                                 VAL_W'($urandom_range(65535)));
            end
            else if (pick < 89)
            begin
                send_request(ACT_CLEAR, ELEM_W'($urandom_range(15)),
                             COL_FIELD_W'($urandom_range(127)),
                             VAL_W'($urandom_range(65535)),
                             VAL_W'($urandom_range(65535)));
                next_chan = 0;
            end
            else
                // Measurement past the active modes, or the top mode when all are in use
                send_request(ACT_MEAS, ELEM_W'(m == 16 ? 15 : $urandom_range(15, m)),
                             COL_FIELD_W'($urandom_range(127)), rand_value(),
                             rand_value());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_LOAD_COEF;
        item_ch.element = '0;
        item_ch.column = '0;
        item_ch.sample_value = '0;
        item_ch.noise = '0;
        requests_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme coefficients, then a full round that writes every noise
        send_request(ACT_LOAD_COEF, 4'd0, 7'd0, 16'h7fff, 16'h0000);
        send_request(ACT_LOAD_COEF, 4'd15, 7'd127, 16'h8000, 16'hffff);
        send_request(ACT_LOAD_COEF, 4'd15, 7'd112, 16'h7fff, 16'h0000);
        send_request(ACT_ACCEL, 4'd0, 7'd0, 16'h1234, 16'h0000);
        for (int i = 0; i < 16; i++)
            send_request(ACT_MEAS, ELEM_W'(i), 7'd0, i[0] ? 16'h7fff : 16'h8000,
                         i[1] ? 16'h7fff : 16'h8000);
        send_request(ACT_CLEAR, 4'd15, 7'd127, 16'hffff, 16'hffff);
        send_request(ACT_MEAS, 4'd15, 7'd0, 16'h0000, 16'h0000);

        // Random phases; register values past the range exercise clamping
        run_phase(31, 7, 7, 7, 16'h8000, 0, 0, 40);
        run_phase(0, 0, 0, 0, 16'h7fff, 46, 0, 100);
        run_phase(3, 2, 2, 3, VAL_W'($urandom_range(65535)), 0, 46, 100);
        run_phase(5, 4, 4, 1, VAL_W'($urandom_range(65535)), 27, 27, 100);
        run_phase(2, 3, 1, 0, VAL_W'($urandom_range(65535)), 0, 0, 110);
        drain();

        $display("sent %0d requests across five register settings, checked %0d commands",
                 requests_sent, commands_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/hsfc_pkg.sv
rtl/hsfc_if.sv
rtl/hsfc_ram.sv
rtl/history_state_feedback_controller.sv
bench/hsfc_checker.sv
bench/tb_history_state_feedback_controller.sv
